/* sv/cnmf_pkg.sv */
// Shared types and constants for the crossing-number minutia finder.
`default_nettype none
package cnmf_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int LINE_AW   = $clog2(MAX_WIDTH);

   localparam int PIXEL_W = 8;
   localparam int FW_W    = 11;
   localparam int FH_W    = 14;
   localparam int COL_W   = 10;
   localparam int ROW_W   = 14;
   localparam int CNT_W   = 16;
   localparam int CODE_W  = 2;
   localparam int CSR_W   = 14;

   localparam logic [PIXEL_W-1:0] PIXEL_RIDGE = 8'd255;
   localparam logic [2:0] CN_ENDING      = 3'd1;
   localparam logic [2:0] CN_BIFURCATION = 3'd3;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd1024;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 14'd1024;

   typedef enum logic {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // [row][col] of 2-bit codes: bit 0 nonzero, bit 1 ridge value
   typedef logic [2:0][2:0][CODE_W-1:0] win_type;

   typedef struct packed {
      logic found;
      logic bif;
   } det_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             frame_end;
      logic             kind;
      logic             found;
   } rsp_type;

endpackage
`default_nettype wire

/* sv/cnmf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cnmf_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

/* sv/cnmf_detect.sv */
// Crossing-number test of the 3x3 window center.
`default_nettype none
module cnmf_detect
   import cnmf_pkg::*;
(
   input  wire logic    enable,
   input  wire win_type win,
   output det_type      det
);

   logic [7:0] ring;
   logic [7:0] diff;
   logic [3:0] changes;
   logic [2:0] cn;

   always_comb begin
      ring[0] = win[0][1][0];
      ring[1] = win[0][2][0];
      ring[2] = win[1][2][0];
      ring[3] = win[2][2][0];
      ring[4] = win[2][1][0];
      ring[5] = win[2][0][0];
      ring[6] = win[1][0][0];
      ring[7] = win[0][0][0];
      changes = '0;
      for (int i = 0; i < 8; i++) begin
         diff[i] = ring[i] ^ ring[(i + 1) % 8];
         changes = changes + {3'd0, diff[i]};
      end
      cn = changes[3:1];
      det.found = enable && win[1][1][1] && (cn == CN_ENDING || cn == CN_BIFURCATION);
      det.bif   = det.found && (cn == CN_BIFURCATION);
   end

endmodule
`default_nettype wire

/* sv/cnmf_out_queue.sv */
// Result register with skid stage.
`default_nettype none
module cnmf_out_queue
   import cnmf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   input  wire logic    rsp_tready,
   output logic         rsp_tvalid,
   output rsp_type      rsp_data,
   output logic         full
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   always_comb begin
      pop           = out_valid_ff && rsp_tready;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = push;
            skid_in       = push_data;
         end else begin
            out_valid_in = push;
            out_in       = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_data   = out_ff;
   assign full       = skid_valid_ff;

endmodule
`default_nettype wire

/* sv/crossing_number_minutia_finder_unit.sv */
// Top level of the crossing-number minutia finder.
//
//   channel  direction  payload
//   req_     in         tdata[7:0] pixel
//   rsp_     out        tdata col,row,count; tuser found,kind; tlast frame_end
//   csr_     in         index 0 frame_width, 1 frame_height
//
// One pixel per cycle while req_tready is high; a result is registered in the output queue at transfer.
// The line store RAM is read one pixel ahead, so its registered read sets the pace.
// After reset all MAX_WIDTH (1024) line store entries are cleared with req_tready low.
// A full skid stage drops req_tready until rsp_tready drains it.
`default_nettype none
module crossing_number_minutia_finder_unit
   import cnmf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [7:0]         req_tdata,   // [7:0] pixel
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [39:0]             rsp_tdata,   // [9:0] col, [23:10] row, [39:24] count
   output logic [1:0]              rsp_tuser,   // [0] found, [1] kind
   output logic                    rsp_tlast,   // frame_end
   input  wire logic               csr_we,
   input  wire logic               csr_index,
   input  wire logic [CSR_W-1:0]   csr_wdata
);

   logic [FW_W-1:0]    frame_width_ff;
   logic [FH_W-1:0]    frame_height_ff;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in, cnt_inc;
   win_type            win_ff, win_in;
   logic [LINE_AW-1:0] clr_addr_ff;
   logic               clr_done_ff;

   logic                   accept;
   logic [CODE_W-1:0]      code, up, mid;
   logic [2*CODE_W-1:0]    line_rdata, line_wdata;
   logic [LINE_AW-1:0]     line_waddr, line_raddr;
   logic                   line_we;
   logic [FW_W-1:0]        width_last;
   logic [COL_W-1:0]       col_last;
   logic [FH_W-1:0]        row_last;
   logic                   last_col, last_row, last_pixel;
   det_type                det;
   rsp_type                res, rsp_data;
   logic                   push, q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[FW_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[FH_W-1:0];
            default:          frame_height_ff <= frame_height_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_done_ff <= 1'b0;
      end else if (!clr_done_ff) begin
         if (clr_addr_ff == LINE_AW'(MAX_WIDTH - 1)) begin
            clr_done_ff <= 1'b1;
         end else begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   assign req_tready = clr_done_ff && !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (frame_width_ff < FW_W'(3)) begin
         width_last = FW_W'(2);
      end else if (frame_width_ff > FW_W'(MAX_WIDTH)) begin
         width_last = FW_W'(MAX_WIDTH - 1);
      end else begin
         width_last = frame_width_ff - 1'b1;
      end
      col_last = width_last[COL_W-1:0];
      row_last = (frame_height_ff < FH_W'(3)) ? FH_W'(2) : frame_height_ff - 1'b1;
      last_col   = col_ff >= col_last;
      last_row   = row_ff >= row_last;
      last_pixel = last_col && last_row;

      code = {req_tdata == PIXEL_RIDGE, req_tdata != '0};
      up   = line_rdata[2*CODE_W-1:CODE_W];
      mid  = line_rdata[CODE_W-1:0];
      for (int k = 0; k < 3; k++) begin
         win_in[k][0] = win_ff[k][1];
         win_in[k][1] = win_ff[k][2];
      end
      win_in[0][2] = up;
      win_in[1][2] = mid;
      win_in[2][2] = code;

      col_in  = last_col ? '0 : col_ff + 1'b1;
      row_in  = last_col ? (last_row ? '0 : row_ff + 1'b1) : row_ff;
      cnt_inc = (det.found && cnt_ff != '1) ? cnt_ff + 1'b1 : cnt_ff;
      cnt_in  = last_pixel ? '0 : cnt_inc;

      line_we    = clr_done_ff ? accept : 1'b1;
      line_waddr = clr_done_ff ? LINE_AW'(col_ff) : clr_addr_ff;
      line_wdata = clr_done_ff ? {mid, code} : '0;
      line_raddr = accept ? LINE_AW'(col_in) : LINE_AW'(col_ff);

      res.found     = det.found;
      res.kind      = det.bif;
      res.col       = det.found ? col_ff - 1'b1 : '0;
      res.row       = det.found ? row_ff - 1'b1 : '0;
      res.count     = cnt_inc;
      res.frame_end = last_pixel;
      push          = accept && (det.found || last_pixel);
   end

   cnmf_ram #(
      .WIDTH (2 * CODE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock (clock),
      .we    (line_we),
      .waddr (line_waddr),
      .wdata (line_wdata),
      .raddr (line_raddr),
      .rdata (line_rdata)
   );

   cnmf_detect u_detect (
      .enable (col_ff >= COL_W'(2) && row_ff >= ROW_W'(2)),
      .win    (win_in),
      .det    (det)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         cnt_ff <= '0;
         win_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
         cnt_ff <= cnt_in;
         win_ff <= win_in;
      end
   end

   cnmf_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (res),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_data   (rsp_data),
      .full       (q_full)
   );

   assign rsp_tdata = {rsp_data.count, rsp_data.row, rsp_data.col};
   assign rsp_tuser = {rsp_data.kind, rsp_data.found};
   assign rsp_tlast = rsp_data.frame_end;

`ifndef NO_ASSERTIONS
   a_no_accept_while_clearing: assert property (
      @(posedge clock) disable iff (reset)
      accept |-> clr_done_ff
   ) else $error("pixel transfer during line store clear");

   a_plain_result_is_frame_end: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> rsp_tlast
   ) else $error("result without minutia is not a frame end");

   a_frame_end_clears_counters: assert property (
      @(posedge clock) disable iff (reset)
      (accept && last_pixel) |=> (col_ff == '0 && row_ff == '0 && cnt_ff == '0)
   ) else $error("counters not cleared after frame end");
`endif

endmodule
`default_nettype wire

/* test/tb.sv */
// Testbench for the crossing-number minutia finder: streams pixel frames and checks reports.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cnmf_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 4_000_000;
   localparam int unsigned DRAIN_PAD   = 16;
   localparam int unsigned RANDOM_PIXELS = 300;

   typedef struct packed {
      logic             found;
      logic             kind;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [CNT_W-1:0] count;
      logic             frame_end;
   } minutia_report_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata = '0;    // [7:0] pixel
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [39:0]        rsp_tdata;         // [9:0] col, [23:10] row, [39:24] count
   logic [1:0]         rsp_tuser;         // [0] found, [1] kind
   logic               rsp_tlast;
   logic               csr_we = 1'b0;
   logic               csr_index = 1'b0;
   logic [CSR_W-1:0]   csr_wdata = '0;

   crossing_number_minutia_finder_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // predicted block state
   logic [CODE_W-1:0] upper_codes [MAX_WIDTH];
   logic [CODE_W-1:0] middle_codes [MAX_WIDTH];
   logic [CODE_W-1:0] win [3][3];
   int unsigned       col_pos = 0;
   int unsigned       row_pos = 0;
   logic [CNT_W-1:0]  minutia_total = '0;
   logic [FW_W-1:0]   width_reg = FRAME_WIDTH_RESET;
   logic [FH_W-1:0]   height_reg = FRAME_HEIGHT_RESET;
   logic              frame_closed = 1'b0;

   minutia_report_type expected_reports [$];
   int unsigned       mismatch_count = 0;
   int unsigned       cycle_count = 0;
   int unsigned       burst_left = 0;
   int unsigned       gap_max = 4;
   int unsigned       stall_left = 0;
   int unsigned       pixels_sent = 0;

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver: ready and stall stretches of random length, sometimes long ready runs
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
      end else if (rsp_tready) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 7);
      end else begin
         rsp_tready <= 1'b1;
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 40);
      end
   end

   function automatic void note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endfunction

   function automatic void find_minutiae(input logic [PIXEL_W-1:0] px);
      logic [CODE_W-1:0] code;
      logic [CODE_W-1:0] up;
      logic [CODE_W-1:0] mid;
      logic [7:0]        ring;
      int unsigned       w, h, idx, changes, k;
      logic              hit, bif, last;
      minutia_report_type rep;
      code = {px == PIXEL_RIDGE, px != '0};
      w = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      h = (height_reg < 3) ? 3 : height_reg;
      idx = (col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1;
      up  = upper_codes[idx];
      mid = middle_codes[idx];
      upper_codes[idx]  = mid;
      middle_codes[idx] = code;
      for (k = 0; k < 3; k++) begin
         win[k][0] = win[k][1];
         win[k][1] = win[k][2];
      end
      win[0][2] = up;
      win[1][2] = mid;
      win[2][2] = code;
      hit = 1'b0;
      bif = 1'b0;
      if (col_pos >= 2 && row_pos >= 2 && win[1][1][1]) begin
         // ring from top, clockwise; bit 0 of each code
         ring = {win[0][0][0], win[1][0][0], win[2][0][0], win[2][1][0],
                 win[2][2][0], win[1][2][0], win[0][2][0], win[0][1][0]};
         changes = 0;
         for (k = 0; k < 8; k++) begin
            if (ring[k] != ring[(k + 1) % 8]) changes++;
         end
         if (changes / 2 == CN_ENDING || changes / 2 == CN_BIFURCATION) begin
            hit = 1'b1;
            bif = (changes / 2 == CN_BIFURCATION);
            if (minutia_total != '1) minutia_total++;
         end
      end
      last = (col_pos >= w - 1) && (row_pos >= h - 1);
      if (hit || last) begin
         rep.found     = hit;
         rep.kind      = bif;
         rep.col       = hit ? COL_W'(col_pos - 1) : '0;
         rep.row       = hit ? ROW_W'(row_pos - 1) : '0;
         rep.count     = minutia_total;
         rep.frame_end = last;
         expected_reports = {expected_reports, rep};
      end
      if (col_pos >= w - 1) begin
         col_pos = 0;
         if (row_pos >= h - 1) begin
            row_pos = 0;
            minutia_total = '0;
            frame_closed = 1'b1;
         end else begin
            row_pos++;
         end
      end else begin
         col_pos++;
      end
   endfunction

   function automatic void check_report();
      minutia_report_type want;
      minutia_report_type got;
      got.found     = rsp_tuser[0];
      got.kind      = rsp_tuser[1];
      got.col       = rsp_tdata[COL_W-1:0];
      got.row       = rsp_tdata[COL_W +: ROW_W];
      got.count     = rsp_tdata[COL_W+ROW_W +: CNT_W];
      got.frame_end = rsp_tlast;
      if (expected_reports.size() == 0) begin
         note_failure($sformatf(
            "unexpected report found=%0d kind=%0d col=%0d row=%0d count=%0d end=%0d",
            got.found, got.kind, got.col, got.row, got.count, got.frame_end));
         return;
      end
      want = expected_reports.pop_front();
      if (got.found !== want.found || got.kind !== want.kind || got.col !== want.col ||
          got.row !== want.row || got.count !== want.count ||
          got.frame_end !== want.frame_end) begin
         note_failure($sformatf({
            "report mismatch: expected found=%0d kind=%0d col=%0d row=%0d count=%0d end=%0d,",
            " got found=%0d kind=%0d col=%0d row=%0d count=%0d end=%0d"},
            want.found, want.kind, want.col, want.row, want.count, want.frame_end,
            got.found, got.kind, got.col, got.row, got.count, got.frame_end));
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) check_report();
   end

   function automatic logic [PIXEL_W-1:0] random_pixel();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 10) return '0;
      if (pick < 17) return PIXEL_RIDGE;
      return PIXEL_W'($urandom_range(1, 254));
   endfunction

   task automatic send_pixel(input logic [PIXEL_W-1:0] px);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         burst_left = $urandom_range(1, 48);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixels_sent++;
      find_minutiae(px);
   endtask

   task automatic wait_for_reports();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   // write both size registers back to back; the block must be idle
   task automatic set_frame_size(input int unsigned width_raw, input int unsigned height_raw);
      csr_we    <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= CSR_W'(width_raw);
      @(posedge clock);
      width_reg = FW_W'(width_raw);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_wdata <= CSR_W'(height_raw);
      @(posedge clock);
      height_reg = FH_W'(height_raw);
      csr_we <= 1'b0;
   endtask

   task automatic finish_frame();
      frame_closed = 1'b0;
      do send_pixel(random_pixel()); while (!frame_closed);
   endtask

   task automatic send_frame(input logic [PIXEL_W-1:0] pixels [9]);
      foreach (pixels[i]) send_pixel(pixels[i]);
   endtask

   task automatic test_small_frames();
      gap_max = 3;
      set_frame_size(2, 0);
      send_frame('{8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0});
      send_frame('{8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255});
      send_frame('{8'd1, 8'd128, 8'd254, 8'd127, 8'd254, 8'd64, 8'd255, 8'd2, 8'd0});
      wait_for_reports();
      set_frame_size(1, 2);
      send_frame('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
      wait_for_reports();
   endtask

   task automatic test_midframe_resize();
      gap_max = 6;
      set_frame_size(3, 16383);
      repeat (120) send_pixel(random_pixel());
      wait_for_reports();
      set_frame_size(3, 20);
      finish_frame();
      wait_for_reports();
      set_frame_size(30, 5);
      repeat (20) send_pixel(random_pixel());
      wait_for_reports();
      set_frame_size(10, 5);
      finish_frame();
      wait_for_reports();
      set_frame_size(1024, 4);
      repeat (1030) send_pixel(random_pixel());
      wait_for_reports();
      set_frame_size(3, 4);
      finish_frame();
      wait_for_reports();
   endtask

   task automatic test_random_frames();
      int unsigned stop_at;
      int unsigned w, h;
      stop_at = pixels_sent + RANDOM_PIXELS;
      while (pixels_sent < stop_at) begin
         case ($urandom_range(0, 7))
            0:       w = $urandom_range(0, 2);
            1:       w = $urandom_range(60, 120);
            default: w = $urandom_range(3, 24);
         endcase
         h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
         gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         set_frame_size(w, h);
         finish_frame();
         wait_for_reports();
      end
   endtask

   initial begin
      foreach (upper_codes[i]) begin
         upper_codes[i]  = '0;
         middle_codes[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_small_frames();
      test_midframe_resize();
      test_random_frames();
      if (expected_reports.size() != 0) mismatch_count++;
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* crossing_number_minutia_finder_unit.f */
sv/cnmf_pkg.sv
sv/cnmf_ram.sv
sv/cnmf_detect.sv
sv/cnmf_out_queue.sv
sv/crossing_number_minutia_finder_unit.sv
test/tb.sv
